// File: hw/rtl/qte_pkg.sv
package qte_pkg;

   localparam int CORDIC_STEPS    = 16;
   localparam int QUAT_FRAC_BITS  = 15;
   localparam int ANGLE_FRAC_BITS = 13;

   // field widths
   localparam int QW  = 16;   // quaternion component
   localparam int PRW = 2 * QW;   // one product
   localparam int SW  = PRW + 2;  // doubled product sum
   localparam int RW  = PRW + 1;  // square-root remainder / partial root
   localparam int SQ_STEPS = QW;  // root bits of a 32-bit radicand
   localparam int ZW  = 35;   // CORDIC angle accumulator, Q2.30 plus headroom
   localparam int PW  = ZW + 1;   // doubled pitch angle
   localparam int MSBW = $clog2(SW);

   localparam int QDEPTH = 4;
   localparam int QPTRW  = $clog2(QDEPTH);

   localparam longint PI_Q30      = 64'd3373259426;
   localparam longint HALF_PI_Q30 = 64'd1686629713;
   localparam int     RSH         = 30 - ANGLE_FRAC_BITS;
   localparam int     NORM_TOP    = 29;

   localparam longint ROLL_LIM_RAW  = (PI_Q30 + (64'd1 << (RSH - 1))) >> RSH;
   localparam longint PITCH_LIM_RAW = (HALF_PI_Q30 + (64'd1 << (RSH - 1))) >> RSH;
   localparam longint ROLL_LIM  = (ROLL_LIM_RAW > 32767) ? 32767 : ROLL_LIM_RAW;
   localparam longint PITCH_LIM = (PITCH_LIM_RAW > 16383) ? 16383 : PITCH_LIM_RAW;

   localparam logic signed [SW-1:0] ONE_VAL = SW'(64'd1 << (2 * QUAT_FRAC_BITS));
   localparam logic signed [ZW-1:0] PI_Z    = ZW'(PI_Q30);
   localparam logic signed [PW-1:0] HALF_P  = PW'(HALF_PI_Q30);
   localparam logic signed [PW-1:0] RND_P   = PW'(64'd1 << (RSH - 1));
   localparam logic signed [PW-1:0] ROLL_LIM_P  = PW'(ROLL_LIM);
   localparam logic signed [PW-1:0] PITCH_LIM_P = PW'(PITCH_LIM);

   localparam int LANES = 3;
   localparam int LANE_ROLL  = 0;
   localparam int LANE_YAW   = 1;
   localparam int LANE_PITCH = 2;

   typedef struct packed {
      logic signed [SW-1:0] rn;
      logic signed [SW-1:0] rd;
      logic signed [SW-1:0] yn;
      logic signed [SW-1:0] yd;
      logic [PRW-1:0]       sp;
      logic [PRW-1:0]       sm;
      logic                 sat;
   } work_type;

   typedef struct packed {
      logic signed [SW-1:0] rn;
      logic signed [SW-1:0] rd;
      logic signed [SW-1:0] yn;
      logic signed [SW-1:0] yd;
      logic                 sat;
      logic [RW-1:0]        ra;
      logic [RW-1:0]        qa;
      logic [RW-1:0]        rb;
      logic [RW-1:0]        qb;
   } sq_type;

   typedef struct packed {
      logic [SW-1:0]        ux;
      logic [SW-1:0]        uy;
      logic                 yneg;
      logic                 zero;
      logic signed [ZW-1:0] z0;
      logic [MSBW-1:0]      msb;
   } norm_type;

   typedef struct packed {
      norm_type [LANES-1:0] ln;
      logic                 sat;
   } nstage_type;

   typedef struct packed {
      logic signed [SW-1:0] x;
      logic signed [SW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } vec_type;

   typedef struct packed {
      vec_type [LANES-1:0] ln;
      logic                sat;
   } vstage_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               sat;
   } rsp_type;

   function automatic logic [30:0] atan_q30(input int i);
      logic [30:0] r;
      case (i)
         0:  r = 31'd843314857;
         1:  r = 31'd497837829;
         2:  r = 31'd263043837;
         3:  r = 31'd133525159;
         4:  r = 31'd67021687;
         5:  r = 31'd33543516;
         6:  r = 31'd16775851;
         7:  r = 31'd8388437;
         8:  r = 31'd4194283;
         9:  r = 31'd2097149;
         10: r = 31'd1048576;
         11: r = 31'd524288;
         12: r = 31'd262144;
         13: r = 31'd131072;
         14: r = 31'd65536;
         15: r = 31'd32768;
         16: r = 31'd16384;
         17: r = 31'd8192;
         18: r = 31'd4096;
         19: r = 31'd2048;
         20: r = 31'd1024;
         21: r = 31'd512;
         22: r = 31'd256;
         23: r = 31'd128;
         default: r = 31'd0;
      endcase
      return r;
   endfunction

   // fold the vector into the right half plane and split off the signs
   function automatic norm_type classify(input logic signed [SW-1:0] y,
                                         input logic signed [SW-1:0] x);
      norm_type n;
      logic signed [SW-1:0] xx;
      logic signed [SW-1:0] yy;
      xx = x;
      yy = y;
      n.z0 = '0;
      n.zero = (x == '0) && (y == '0);
      if (x < 0) begin
         n.z0 = (y >= 0) ? PI_Z : -PI_Z;
         xx = -x;
         yy = -y;
      end
      n.yneg = yy < 0;
      n.ux = xx;
      n.uy = n.yneg ? -yy : yy;
      n.msb = '0;
      return n;
   endfunction

   // round to the output grid and clamp to the symmetric limit
   function automatic logic signed [PW-1:0] pack_angle(input logic signed [PW-1:0] z,
                                                       input logic signed [PW-1:0] lim);
      logic signed [PW-1:0] r;
      r = (z + RND_P) >>> RSH;
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/qte_front.sv
module qte_front import qte_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic signed [QW-1:0] req_quat_w,
   input  logic signed [QW-1:0] req_quat_x,
   input  logic signed [QW-1:0] req_quat_y,
   input  logic signed [QW-1:0] req_quat_z,
   output logic                 q_push,
   input  logic                 q_full,
   output work_type             q_data
);

   logic adv;
   logic a_vld_ff, b_vld_ff;
   logic signed [PRW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, xz_ff;
   work_type b_ff, b_in;
   logic signed [PRW:0] t_r, t_rd, t_y, t_yd, t_s;
   logic signed [SW-1:0] s;

   assign adv      = !b_vld_ff || !q_full;
   assign req_full = !adv;
   assign q_push   = b_vld_ff && !q_full;
   assign q_data   = b_ff;

   // products
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_push;
         b_vld_ff <= a_vld_ff;
      end
      if (adv) begin
         wx_ff <= req_quat_w * req_quat_x;
         yz_ff <= req_quat_y * req_quat_z;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         wz_ff <= req_quat_w * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
         wy_ff <= req_quat_w * req_quat_y;
         xz_ff <= req_quat_x * req_quat_z;
         b_ff  <= b_in;
      end
   end

   // product sums, clamp of the pitch sine
   always_comb begin
      t_r  = (PRW+1)'(wx_ff) + (PRW+1)'(yz_ff);
      t_rd = (PRW+1)'(xx_ff) + (PRW+1)'(yy_ff);
      t_y  = (PRW+1)'(wz_ff) + (PRW+1)'(xy_ff);
      t_yd = (PRW+1)'(yy_ff) + (PRW+1)'(zz_ff);
      t_s  = (PRW+1)'(wy_ff) - (PRW+1)'(xz_ff);
      b_in.rn = {t_r, 1'b0};
      b_in.rd = ONE_VAL - {t_rd, 1'b0};
      b_in.yn = {t_y, 1'b0};
      b_in.yd = ONE_VAL - {t_yd, 1'b0};
      s = {t_s, 1'b0};
      b_in.sat = 1'b0;
      if (s > ONE_VAL) begin
         s = ONE_VAL;
         b_in.sat = 1'b1;
      end else if (s < -ONE_VAL) begin
         s = -ONE_VAL;
         b_in.sat = 1'b1;
      end
      b_in.sp = PRW'(ONE_VAL + s);
      b_in.sm = PRW'(ONE_VAL - s);
   end

endmodule

// File: hw/rtl/qte_queue.sv
module qte_queue import qte_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  work_type push_data,
   input  logic     pop,
   output logic     empty,
   output work_type pop_data
);

   work_type           mem_ff [QDEPTH];
   logic [QPTRW-1:0]   wp_ff, rp_ff;
   logic [QPTRW:0]     cnt_ff;
   logic               do_push, do_pop;

   assign full     = cnt_ff == (QPTRW+1)'(QDEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (do_pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (QPTRW+1)'(do_push) - (QPTRW+1)'(do_pop);
      end
      if (do_push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/qte_back.sv
module qte_back import qte_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  work_type q_data,
   output logic     q_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   logic adv, res_full, res_push, res_pop;

   logic                v0_ff;
   work_type            w0_ff;
   logic [SQ_STEPS-1:0] sq_v_ff;
   sq_type              sq_ff [SQ_STEPS];
   logic                n1_v_ff, n2_v_ff, c0_v_ff;
   nstage_type          n1_ff, n1_in, n2_ff, n2_in;
   vstage_type          c0_ff, c0_in;
   logic [CORDIC_STEPS-1:0] cs_v_ff;
   vstage_type          cs_ff [CORDIC_STEPS];

   rsp_type             buf_ff [2];
   rsp_type             res_in;
   logic                wp_ff, rp_ff;
   logic [1:0]          cnt_ff;

   assign res_full = cnt_ff == 2'd2;
   assign adv      = !cs_v_ff[CORDIC_STEPS-1] || !res_full;
   assign res_push = cs_v_ff[CORDIC_STEPS-1] && !res_full;
   assign q_pop    = adv && !q_empty;
   assign rsp_empty = cnt_ff == 2'd0;
   assign res_pop  = rsp_pop && !rsp_empty;
   assign rsp_data = buf_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         sq_v_ff <= '0;
         n1_v_ff <= 1'b0;
         n2_v_ff <= 1'b0;
         c0_v_ff <= 1'b0;
         cs_v_ff <= '0;
      end else if (adv) begin
         v0_ff   <= !q_empty;
         sq_v_ff <= {sq_v_ff[SQ_STEPS-2:0], v0_ff};
         n1_v_ff <= sq_v_ff[SQ_STEPS-1];
         n2_v_ff <= n1_v_ff;
         c0_v_ff <= n2_v_ff;
         cs_v_ff <= {cs_v_ff[CORDIC_STEPS-2:0], c0_v_ff};
      end
      if (adv) begin
         w0_ff <= q_data;
         n1_ff <= n1_in;
         n2_ff <= n2_in;
         c0_ff <= c0_in;
      end
   end

   // square roots of 1+s and 1-s, one root bit per stage
   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      localparam logic [RW:0] BIT = (RW+1)'(1) << (2 * (SQ_STEPS - 1 - j));
      sq_type src, nxt;
      logic [RW:0] ta, tb;
      if (j == 0) begin : g_first
         always_comb begin
            src.rn  = w0_ff.rn;
            src.rd  = w0_ff.rd;
            src.yn  = w0_ff.yn;
            src.yd  = w0_ff.yd;
            src.sat = w0_ff.sat;
            src.ra  = RW'(w0_ff.sp);
            src.rb  = RW'(w0_ff.sm);
            src.qa  = '0;
            src.qb  = '0;
         end
      end else begin : g_rest
         assign src = sq_ff[j-1];
      end
      always_comb begin
         nxt = src;
         ta = {1'b0, src.qa} + BIT;
         tb = {1'b0, src.qb} + BIT;
         if ({1'b0, src.ra} >= ta) begin
            nxt.ra = RW'({1'b0, src.ra} - ta);
            nxt.qa = RW'(({1'b0, src.qa} >> 1) + BIT);
         end else begin
            nxt.qa = src.qa >> 1;
         end
         if ({1'b0, src.rb} >= tb) begin
            nxt.rb = RW'({1'b0, src.rb} - tb);
            nxt.qb = RW'(({1'b0, src.qb} >> 1) + BIT);
         end else begin
            nxt.qb = src.qb >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[j] <= nxt;
         end
      end
   end

   // sign folding for the three atan2 lanes
   always_comb begin
      n1_in.sat = sq_ff[SQ_STEPS-1].sat;
      n1_in.ln[LANE_ROLL]  = classify(sq_ff[SQ_STEPS-1].rn, sq_ff[SQ_STEPS-1].rd);
      n1_in.ln[LANE_YAW]   = classify(sq_ff[SQ_STEPS-1].yn, sq_ff[SQ_STEPS-1].yd);
      n1_in.ln[LANE_PITCH] = classify(SW'(sq_ff[SQ_STEPS-1].qa), SW'(sq_ff[SQ_STEPS-1].qb));
   end

   // leading-one position of the larger magnitude
   always_comb begin
      logic [SW-1:0] m;
      n2_in = n1_ff;
      for (int l = 0; l < LANES; l++) begin
         m = (n1_ff.ln[l].ux > n1_ff.ln[l].uy) ? n1_ff.ln[l].ux : n1_ff.ln[l].uy;
         n2_in.ln[l].msb = '0;
         for (int k = 0; k < SW; k++) begin
            if (m[k]) begin
               n2_in.ln[l].msb = MSBW'(k);
            end
         end
      end
   end

   // shift both operands so the larger lands just under 2^30
   always_comb begin
      logic [SW-1:0] ux, uy;
      c0_in.sat = n2_ff.sat;
      for (int l = 0; l < LANES; l++) begin
         if (n2_ff.ln[l].msb > MSBW'(NORM_TOP)) begin
            ux = n2_ff.ln[l].ux >> (n2_ff.ln[l].msb - MSBW'(NORM_TOP));
            uy = n2_ff.ln[l].uy >> (n2_ff.ln[l].msb - MSBW'(NORM_TOP));
         end else begin
            ux = n2_ff.ln[l].ux << (MSBW'(NORM_TOP) - n2_ff.ln[l].msb);
            uy = n2_ff.ln[l].uy << (MSBW'(NORM_TOP) - n2_ff.ln[l].msb);
         end
         c0_in.ln[l].x    = ux;
         c0_in.ln[l].y    = n2_ff.ln[l].yneg ? -uy : uy;
         c0_in.ln[l].z    = n2_ff.ln[l].z0;
         c0_in.ln[l].zero = n2_ff.ln[l].zero;
      end
   end

   // vectoring CORDIC, one micro-rotation per stage on all lanes
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q30(i));
      vstage_type src, nxt;
      if (i == 0) begin : g_first
         assign src = c0_ff;
      end else begin : g_rest
         assign src = cs_ff[i-1];
      end
      always_comb begin
         nxt = src;
         for (int l = 0; l < LANES; l++) begin
            if (src.ln[l].y >= 0) begin
               nxt.ln[l].x = src.ln[l].x + (src.ln[l].y >>> i);
               nxt.ln[l].y = src.ln[l].y - (src.ln[l].x >>> i);
               nxt.ln[l].z = src.ln[l].z + ATAN;
            end else begin
               nxt.ln[l].x = src.ln[l].x - (src.ln[l].y >>> i);
               nxt.ln[l].y = src.ln[l].y + (src.ln[l].x >>> i);
               nxt.ln[l].z = src.ln[l].z - ATAN;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            cs_ff[i] <= nxt;
         end
      end
   end

   // round, clamp and pack
   always_comb begin
      vstage_type f;
      logic signed [PW-1:0] zr, zy, zp;
      f  = cs_ff[CORDIC_STEPS-1];
      zr = f.ln[LANE_ROLL].zero ? '0 : PW'(f.ln[LANE_ROLL].z);
      zy = f.ln[LANE_YAW].zero  ? '0 : PW'(f.ln[LANE_YAW].z);
      zp = f.ln[LANE_PITCH].zero ? '0 : PW'(f.ln[LANE_PITCH].z);
      zp = {zp[PW-2:0], 1'b0} - HALF_P;
      res_in.roll  = 16'(pack_angle(zr, ROLL_LIM_P));
      res_in.yaw   = 16'(pack_angle(zy, ROLL_LIM_P));
      res_in.pitch = 15'(pack_angle(zp, PITCH_LIM_P));
      res_in.sat   = f.sat;
   end

   // two-entry result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (res_push) begin
            wp_ff <= !wp_ff;
         end
         if (res_pop) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_ff + 2'(res_push) - 2'(res_pop);
      end
      if (res_push) begin
         buf_ff[wp_ff] <= res_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer count out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(cs_ff[CORDIC_STEPS-1]) && cs_v_ff[CORDIC_STEPS-1])
      else $error("pipeline moved during a stall");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      res_push |=> !rsp_empty)
      else $error("pushed result not visible");

endmodule

// File: hw/rtl/quaternion_to_euler_angles.sv
// Quaternion to roll/pitch/yaw. Push one Q1.15 quaternion (w, x, y, z) per
// cycle while full is low; pop roll and yaw in Q3.13 and pitch in Q2.13 radians,
// in order, while empty is low. The block sustains one item per cycle while the
// consumer keeps popping. On the way from push to result, products and sums are
// registered in the front, then pass a four-entry queue, then 16 square-root
// stages, three normalization stages and 16 CORDIC stages in the back, which
// writes a two-entry result buffer. A stalled consumer first fills that buffer,
// then freezes the back pipeline, then fills the queue, and only then raises full. Roll and yaw come from
// atan2 of the raw product sums; pitch is 2*atan2(sqrt(1+s), sqrt(1-s)) - pi/2
// with s = 2(wy - xz) clamped to [-1, 1], and pitch_saturated reports a clamp
// for non-unit input. Angles are rounded half up and limited to +-pi
// (+-pi/2 for pitch).
module quaternion_to_euler_angles import qte_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic signed [QW-1:0] req_quat_w,
   input  logic signed [QW-1:0] req_quat_x,
   input  logic signed [QW-1:0] req_quat_y,
   input  logic signed [QW-1:0] req_quat_z,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic signed [15:0]   rsp_roll_angle,
   output logic signed [14:0]   rsp_pitch_angle,
   output logic signed [15:0]   rsp_yaw_angle,
   output logic                 rsp_pitch_saturated
);

   logic     q_push, q_full, q_pop, q_empty;
   work_type q_in, q_out;
   rsp_type  rsp;

   // front: products and sums of the quaternion terms
   qte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_quat_w (req_quat_w),
      .req_quat_x (req_quat_x),
      .req_quat_y (req_quat_y),
      .req_quat_z (req_quat_z),
      .q_push     (q_push),
      .q_full     (q_full),
      .q_data     (q_in)
   );

   // decouple front from back
   qte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_data (q_in),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   // back: square roots, CORDIC lanes and result buffer
   qte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp)
   );

   assign rsp_roll_angle      = rsp.roll;
   assign rsp_pitch_angle     = rsp.pitch;
   assign rsp_yaw_angle       = rsp.yaw;
   assign rsp_pitch_saturated = rsp.sat;

endmodule
